// ===== rtl/odmp_pkg.sv =====
// Shared types, constants and lookup tables of the ordered-dither monochrome packer.
package odmp_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_SCALE = 8;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int SROW_W  = 10;
	localparam int OROW_W  = 11;
	localparam int SCALE_W = 4;
	localparam int WIDTH_W = 11;
	localparam int SKIP_W  = 4;
	localparam int BCNT_W  = 3;
	localparam int BCOL_W  = 8;
	localparam int THR_W   = 7;
	localparam int RECIP_W = 11;
	localparam int RECIP_SH = 10;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_TABLE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_SCALE_MODE  = 2'd0,
		CFG_LINE_WIDTH  = 2'd1,
		CFG_WHITE_VALUE = 2'd2,
		CFG_BLACK_VALUE = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SHIFT_NONE = 2'd0,
		SHIFT_ONE  = 2'd1,
		SHIFT_TWO  = 2'd2
	} shift_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale_mode;
		logic [WIDTH_W-1:0] line_width;
		logic               white_value;
		logic               black_value;
	} cfg_t;

	typedef struct packed {
		logic              clr_before;
		shift_t            up_shift;
		logic              lo_shift;
		logic [3:0]        bits;
		logic [1:0]        nres;
		logic              clr_up;
		logic              clr_lo;
		logic [OROW_W-1:0] row;
		logic [BCOL_W-1:0] col;
	} q_entry_t;

	typedef struct packed {
		logic [7:0]        mono_byte;
		logic [OROW_W-1:0] row;
		logic [BCOL_W-1:0] col;
		logic              last;
	} res_t;

	localparam logic [THR_W-1:0] THR4 [4][4] = '{
		'{7'd56, 7'd24, 7'd120, 7'd88},
		'{7'd96, 7'd32, 7'd64,  7'd16},
		'{7'd72, 7'd112, 7'd8,  7'd40},
		'{7'd0,  7'd80, 7'd48,  7'd104}
	};

	localparam logic [THR_W-1:0] THR8 [8][8] = '{
		'{7'd2,  7'd118, 7'd30, 7'd110, 7'd4,  7'd112, 7'd24, 7'd104},
		'{7'd66, 7'd34,  7'd94, 7'd62,  7'd68, 7'd36,  7'd88, 7'd56},
		'{7'd18, 7'd98,  7'd10, 7'd126, 7'd20, 7'd100, 7'd12, 7'd120},
		'{7'd82, 7'd50,  7'd74, 7'd42,  7'd84, 7'd52,  7'd76, 7'd44},
		'{7'd6,  7'd114, 7'd26, 7'd106, 7'd0,  7'd116, 7'd28, 7'd108},
		'{7'd70, 7'd38,  7'd90, 7'd58,  7'd64, 7'd32,  7'd92, 7'd60},
		'{7'd22, 7'd102, 7'd14, 7'd122, 7'd16, 7'd96,  7'd8,  7'd124},
		'{7'd86, 7'd54,  7'd78, 7'd46,  7'd80, 7'd48,  7'd72, 7'd40}
	};

	// Rounded-up reciprocal of the scale, exact for quotients of 7-bit values.
	function automatic logic [RECIP_W-1:0] scale_recip(input logic [SCALE_W-1:0] s);
		logic [RECIP_W-1:0] r;
		case (s)
			4'd2:    r = 11'd512;
			4'd3:    r = 11'd342;
			4'd4:    r = 11'd256;
			4'd5:    r = 11'd205;
			4'd6:    r = 11'd171;
			4'd7:    r = 11'd147;
			4'd8:    r = 11'd128;
			default: r = 11'd1024;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/odmp_front.sv =====
// Front end: accepts requests, owns the grey map, tracks raster position and computes dither bits.
module odmp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  odmp_pkg::cfg_t      cfg,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  logic                op,
	input  logic [7:0]          pixel,
	input  logic                frame_start,
	input  logic [7:0]          table_index,
	input  logic [7:0]          table_value,
	output logic                q_push,
	output odmp_pkg::q_entry_t  q_entry,
	input  logic                q_full
);
	import odmp_pkg::*;

	logic [7:0] grey_mem [256];
	logic [7:0] grey_q;

	logic [COL_W-1:0]  col_q;
	logic [SROW_W-1:0] srow_q;
	logic [OROW_W-1:0] orow_q;
	logic [SKIP_W-1:0] cskip_q;
	logic [SKIP_W-1:0] rskip_q;
	logic [BCNT_W-1:0] bcnt_q;

	logic                 valid_s1;
	q_entry_t             ent_s1;
	logic [THR_W-1:0]     thr_s1 [4];

	logic accept;
	logic pix_acc;

	logic [COL_W-1:0]   sc;
	logic [SROW_W-1:0]  sr;
	logic [OROW_W-1:0]  orow;
	logic [SKIP_W-1:0]  cskip;
	logic [SKIP_W-1:0]  rskip;
	logic [BCNT_W-1:0]  bc;
	logic [SCALE_W-1:0] s_sat;
	logic [WIDTH_W-1:0] width_sat;
	logic               dbl;
	logic               kept;
	logic               emit1;
	logic               emit2;
	logic               line_end;
	logic [1:0]         k;
	logic [2:0]         z_up;
	logic [2:0]         z_lo;
	logic [2:0]         c0;
	logic [2:0]         c1;
	logic [SKIP_W:0]    cskip_inc;
	logic [SKIP_W:0]    rskip_inc;
	logic [SKIP_W-1:0]  cskip_step;
	logic [SKIP_W-1:0]  rskip_step;
	logic [6:0]         col_div_in;
	logic [17:0]        col_prod;

	logic [COL_W-1:0]  col_n;
	logic [SROW_W-1:0] srow_n;
	logic [OROW_W-1:0] orow_n;
	logic [SKIP_W-1:0] cskip_n;
	logic [SKIP_W-1:0] rskip_n;
	logic [BCNT_W-1:0] bcnt_n;
	q_entry_t          ent_n;
	logic [THR_W-1:0]  thr_n [4];
	logic [3:0]        dith;

	assign pix_stall = valid_s1 && q_full;
	assign accept    = pix_valid && !pix_stall;
	assign pix_acc   = accept && (op == OP_PIXEL);
	assign q_push    = valid_s1 && !q_full;

	always_ff @(posedge clk) begin
		if (accept && op == OP_TABLE) begin
			grey_mem[table_index] <= table_value;
		end
		if (pix_acc) begin
			grey_q <= grey_mem[pixel];
		end
	end

	always_comb begin
		sc    = frame_start ? '0 : col_q;
		sr    = frame_start ? '0 : srow_q;
		orow  = frame_start ? '0 : orow_q;
		cskip = frame_start ? '0 : cskip_q;
		rskip = frame_start ? '0 : rskip_q;
		bc    = frame_start ? '0 : bcnt_q;

		s_sat     = (cfg.scale_mode > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : cfg.scale_mode;
		width_sat = (cfg.line_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : cfg.line_width;
		dbl       = (s_sat == '0);

		k    = bc[1:0];
		z_up = {sr[1:0], 1'b0};
		z_lo = {sr[1:0], 1'b1};
		c0   = {k, 1'b0};
		c1   = {k, 1'b1};

		thr_n[0] = dbl ? THR8[z_up][c0] : THR4[orow[1:0]][bc[1:0]];
		thr_n[1] = THR8[z_up][c1];
		thr_n[2] = THR8[z_lo][c0];
		thr_n[3] = THR8[z_lo][c1];

		kept     = (rskip == '0) && (cskip == '0);
		emit1    = !dbl && kept && (bc == BCNT_W'(7));
		emit2    = dbl && (k == 2'd3);
		line_end = ((WIDTH_W'(sc) + WIDTH_W'(1)) >= width_sat);

		cskip_inc  = {1'b0, cskip} + (SKIP_W+1)'(1);
		rskip_inc  = {1'b0, rskip} + (SKIP_W+1)'(1);
		cskip_step = (cskip_inc >= {1'b0, s_sat}) ? '0 : cskip_inc[SKIP_W-1:0];
		rskip_step = (rskip_inc >= {1'b0, s_sat}) ? '0 : rskip_inc[SKIP_W-1:0];

		col_div_in = sc[COL_W-1:3];
		col_prod   = 18'(col_div_in) * 18'(scale_recip(s_sat));

		if (dbl) begin
			bcnt_n  = emit2 ? '0 : BCNT_W'({1'b0, k} + 3'd1);
			cskip_n = cskip;
		end else begin
			bcnt_n  = emit1 ? '0 : (kept ? bc + BCNT_W'(1) : bc);
			cskip_n = cskip_step;
		end

		col_n   = sc + COL_W'(1);
		srow_n  = sr;
		orow_n  = orow;
		rskip_n = rskip;
		if (line_end) begin
			col_n   = '0;
			cskip_n = '0;
			bcnt_n  = '0;
			srow_n  = sr + SROW_W'(1);
			if (dbl) begin
				orow_n = orow + OROW_W'(2);
			end else begin
				orow_n  = (rskip == '0) ? orow + OROW_W'(1) : orow;
				rskip_n = rskip_step;
			end
		end

		ent_n.clr_before = frame_start;
		ent_n.up_shift   = dbl ? SHIFT_TWO : (kept ? SHIFT_ONE : SHIFT_NONE);
		ent_n.lo_shift   = dbl;
		ent_n.bits       = '0;
		ent_n.nres       = emit2 ? 2'd2 : (emit1 ? 2'd1 : 2'd0);
		ent_n.clr_up     = emit1 || emit2 || line_end;
		ent_n.clr_lo     = emit2 || line_end;
		ent_n.row        = orow;
		ent_n.col        = dbl ? BCOL_W'(sc[COL_W-1:2]) : BCOL_W'(col_prod[RECIP_SH+6:RECIP_SH]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			srow_q   <= '0;
			orow_q   <= '0;
			cskip_q  <= '0;
			rskip_q  <= '0;
			bcnt_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pix_acc) begin
				col_q   <= col_n;
				srow_q  <= srow_n;
				orow_q  <= orow_n;
				cskip_q <= cskip_n;
				rskip_q <= rskip_n;
				bcnt_q  <= bcnt_n;
			end
			if (pix_acc) begin
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			ent_s1 <= ent_n;
			for (int i = 0; i < 4; i++) begin
				thr_s1[i] <= thr_n[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dith[3-i] = (grey_q > {1'b0, thr_s1[i]}) ? cfg.white_value : cfg.black_value;
		end
		q_entry      = ent_s1;
		q_entry.bits = dith;
	end

endmodule

// ===== rtl/odmp_queue.sv =====
// Short first-in first-out queue of classified pixels between the front and back ends.
module odmp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  odmp_pkg::q_entry_t din,
	output logic               full,
	input  logic               pop,
	output odmp_pkg::q_entry_t dout,
	output logic               valid
);
	import odmp_pkg::*;

	q_entry_t        store [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign valid = (count_q != '0);
	assign dout  = store[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

// ===== rtl/odmp_back.sv =====
// Back end: packs dither bits into bytes and holds finished bytes in a two-slot output buffer.
module odmp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  odmp_pkg::q_entry_t   q_entry,
	output logic                 q_pop,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output logic [7:0]           mono_byte,
	output logic [10:0]          out_row,
	output logic [7:0]           byte_column,
	output logic                 last
);
	import odmp_pkg::*;

	logic [7:0] upper_q;
	logic [7:0] lower_q;
	logic [1:0] cnt_q;
	res_t       slot0_q;
	res_t       slot1_q;

	logic       out_acc;
	logic [1:0] rem;
	logic [1:0] npush;
	logic [7:0] u0;
	logic [7:0] u1;
	logic [7:0] l0;
	logic [7:0] l1;
	res_t       r0;
	res_t       r1;
	res_t       sh0;

	assign byte_valid  = (cnt_q != 2'd0);
	assign mono_byte   = slot0_q.mono_byte;
	assign out_row     = slot0_q.row;
	assign byte_column = slot0_q.col;
	assign last        = slot0_q.last;

	always_comb begin
		out_acc = byte_valid && !byte_stall;
		rem     = cnt_q - {1'b0, out_acc};
		q_pop   = q_valid && (({1'b0, rem} + {1'b0, q_entry.nres}) <= 3'd2);
		npush   = q_pop ? q_entry.nres : 2'd0;

		u0 = q_entry.clr_before ? 8'd0 : upper_q;
		l0 = q_entry.clr_before ? 8'd0 : lower_q;
		case (q_entry.up_shift)
			SHIFT_ONE: u1 = {u0[6:0], q_entry.bits[3]};
			SHIFT_TWO: u1 = {u0[5:0], q_entry.bits[3:2]};
			default:   u1 = u0;
		endcase
		l1 = q_entry.lo_shift ? {l0[5:0], q_entry.bits[1:0]} : l0;

		r0.mono_byte = u1;
		r0.row       = q_entry.row;
		r0.col       = q_entry.col;
		r0.last      = (q_entry.nres == 2'd1);
		r1.mono_byte = l1;
		r1.row       = q_entry.row + OROW_W'(1);
		r1.col       = q_entry.col;
		r1.last      = 1'b1;

		sh0 = out_acc ? slot1_q : slot0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
			cnt_q   <= '0;
		end else begin
			cnt_q <= rem + npush;
			if (q_pop) begin
				upper_q <= q_entry.clr_up ? 8'd0 : u1;
				lower_q <= q_entry.clr_lo ? 8'd0 : l1;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= (rem == 2'd0 && npush != 2'd0) ? r0 : sh0;
		if (rem == 2'd0 && npush == 2'd2) begin
			slot1_q <= r1;
		end else if (rem == 2'd1 && npush != 2'd0) begin
			slot1_q <= r0;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("output buffer count out of range");

	a_pair_fits: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_entry.nres == 2'd2 |-> rem == 2'd0)
		else $error("byte pair pushed into an occupied buffer");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from an empty queue");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && !last |=> byte_valid)
		else $error("second byte of a pair missing");

endmodule

// ===== rtl/ordered_dither_mono_packer.sv =====
// Top level of the ordered-dither monochrome packer with its configuration registers.
//
// Pixel channel (pix_valid / pix_stall): one request per cycle, either a source grey
// pixel in raster order (op = 0) or a grey map write (op = 1). A request is taken at
// a rising edge with pix_valid high and pix_stall low.
// Byte channel (byte_valid / byte_stall): packed monochrome bytes with their output
// row and byte column; last marks the final byte caused by one pixel.
// Configuration channel (cfg_valid / cfg_ready): always ready; write only while idle.
// Throughput is one request per cycle while pix_stall is low. Double mode gives two
// bytes per four pixels and reduce mode one byte per eight kept pixels, both below
// the one-byte-per-cycle output. A byte passes from the request that completes it
// through a grey map read, a threshold compare into a four-entry queue and bit
// packing into a two-slot output buffer.
// When the receiver stalls, bytes wait in the output buffer and the queue fills; the
// pixel channel stalls once the queue is full and the compare stage holds a pixel.
// Reset clears all counters, the packing state and the buffers, and loads the
// configuration defaults. The grey map is not cleared and must be written before use.
module ordered_dither_mono_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  logic        op,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	input  logic [7:0]  table_index,
	input  logic [7:0]  table_value,
	output logic        byte_valid,
	input  logic        byte_stall,
	output logic [7:0]  mono_byte,
	output logic [10:0] out_row,
	output logic [7:0]  byte_column,
	output logic        last
);
	import odmp_pkg::*;

	cfg_t     cfg_q;
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;
	q_entry_t q_din;
	q_entry_t q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_mode  <= SCALE_W'(1);
			cfg_q.line_width  <= WIDTH_W'(320);
			cfg_q.white_value <= 1'b1;
			cfg_q.black_value <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SCALE_MODE:  cfg_q.scale_mode  <= cfg_data[SCALE_W-1:0];
				CFG_LINE_WIDTH:  cfg_q.line_width  <= cfg_data[WIDTH_W-1:0];
				CFG_WHITE_VALUE: cfg_q.white_value <= cfg_data[0];
				CFG_BLACK_VALUE: cfg_q.black_value <= cfg_data[0];
				default: ;
			endcase
		end
	end

	odmp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.op          (op),
		.pixel       (pixel),
		.frame_start (frame_start),
		.table_index (table_index),
		.table_value (table_value),
		.q_push      (q_push),
		.q_entry     (q_din),
		.q_full      (q_full)
	);

	odmp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	odmp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (q_dout),
		.q_pop       (q_pop),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.mono_byte   (mono_byte),
		.out_row     (out_row),
		.byte_column (byte_column),
		.last        (last)
	);

endmodule

// ===== test/ordered_dither_mono_packer_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the ordered-dither monochrome packer with its own dither and packing predictor.
module ordered_dither_mono_packer_test;
	import odmp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int REPORT_LIMIT   = 10;

	localparam int BAYER4 [0:3][0:3] = '{
		'{56, 24, 120, 88},
		'{96, 32, 64, 16},
		'{72, 112, 8, 40},
		'{0, 80, 48, 104}
	};

	localparam int BAYER8 [0:7][0:7] = '{
		'{2, 118, 30, 110, 4, 112, 24, 104},
		'{66, 34, 94, 62, 68, 36, 88, 56},
		'{18, 98, 10, 126, 20, 100, 12, 120},
		'{82, 50, 74, 42, 84, 52, 76, 44},
		'{6, 114, 26, 106, 0, 116, 28, 108},
		'{70, 38, 90, 58, 64, 32, 92, 60},
		'{22, 102, 14, 122, 16, 96, 8, 124},
		'{86, 54, 78, 46, 80, 48, 72, 40}
	};

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		op_t        op;
		logic [7:0] pixel;
		logic       frame_start;
		logic [7:0] table_index;
		logic [7:0] table_value;
	} pixel_request_t;

	typedef struct {
		logic [7:0]  mono_byte;
		logic [10:0] out_row;
		logic [7:0]  byte_column;
		logic        last;
	} mono_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SCALE_MODE;
	logic [10:0] cfg_data = '0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	op_t         op = OP_PIXEL;
	logic [7:0]  pixel = '0;
	logic        frame_start = 1'b0;
	logic [7:0]  table_index = '0;
	logic [7:0]  table_value = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  mono_byte;
	logic [10:0] out_row;
	logic [7:0]  byte_column;
	logic        last;

	pixel_request_t pixel_requests [$];
	mono_result_t   pending_bytes [$];
	pixel_request_t driven_request;
	int             mapped_levels [$];
	bit             level_mapped [256];

	int queued_total = 0;
	int accepted_total = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	logic [3:0]  scale_reg = 4'd1;
	logic [10:0] width_reg = 11'd320;
	logic        white_reg = 1'b1;
	logic        black_reg = 1'b0;
	logic [7:0]  grey_map [256];
	int src_col = 0;
	int src_row = 0;
	int dst_row = 0;
	int col_skip = 0;
	int row_skip = 0;
	int upper = 0;
	int lower = 0;
	int bit_cnt = 0;

	ordered_dither_mono_packer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.op          (op),
		.pixel       (pixel),
		.frame_start (frame_start),
		.table_index (table_index),
		.table_value (table_value),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.mono_byte   (mono_byte),
		.out_row     (out_row),
		.byte_column (byte_column),
		.last        (last)
	);

	always #1 clk = ~clk;

	function automatic int tone(input int grey, input int threshold);
		return (grey > threshold) ? int'(white_reg) : int'(black_reg);
	endfunction

	function automatic void clear_line();
		src_col = 0;
		col_skip = 0;
		upper = 0;
		lower = 0;
		bit_cnt = 0;
	endfunction

	function automatic void push_byte(input int value, input int row, input int column,
			input bit is_last);
		mono_result_t res;
		res.mono_byte = 8'(value);
		res.out_row = 11'(row);
		res.byte_column = 8'(column);
		res.last = is_last;
		pending_bytes.push_back(res);
	endfunction

	// Advances the predicted block state by one accepted request and queues the bytes it completes.
	function automatic void pack_request(input pixel_request_t r);
		int w;
		int s;
		int g;
		int z;
		int k;
		if (r.op == OP_TABLE) begin
			grey_map[r.table_index] = r.table_value;
			return;
		end
		if (r.frame_start) begin
			clear_line();
			src_row = 0;
			dst_row = 0;
			row_skip = 0;
		end
		w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		s = (scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg);
		g = int'(grey_map[r.pixel]);
		if (s == 0) begin
			z = (src_row % 4) * 2;
			k = bit_cnt % 4;
			upper = ((upper << 2) | (tone(g, BAYER8[z][2 * k]) << 1)
				| tone(g, BAYER8[z][2 * k + 1])) & 255;
			lower = ((lower << 2) | (tone(g, BAYER8[z + 1][2 * k]) << 1)
				| tone(g, BAYER8[z + 1][2 * k + 1])) & 255;
			if (k == 3) begin
				push_byte(upper, dst_row, src_col >> 2, 1'b0);
				push_byte(lower, dst_row + 1, src_col >> 2, 1'b1);
				upper = 0;
				lower = 0;
				bit_cnt = 0;
			end else begin
				bit_cnt = k + 1;
			end
		end else begin
			if (row_skip == 0 && col_skip == 0) begin
				z = dst_row % 4;
				upper = ((upper << 1) | tone(g, BAYER4[z][bit_cnt % 4])) & 255;
				if (bit_cnt == 7) begin
					push_byte(upper, dst_row, src_col / (8 * s), 1'b1);
					upper = 0;
					bit_cnt = 0;
				end else begin
					bit_cnt = bit_cnt + 1;
				end
			end
			col_skip = (col_skip + 1 >= s) ? 0 : col_skip + 1;
		end
		if (src_col + 1 >= w) begin
			clear_line();
			src_row = (src_row + 1) & 1023;
			if (s == 0) begin
				dst_row = (dst_row + 2) & 2047;
			end else begin
				if (row_skip == 0) dst_row = (dst_row + 1) & 2047;
				row_skip = (row_skip + 1 >= s) ? 0 : row_skip + 1;
			end
		end else begin
			src_col = (src_col + 1) & 1023;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			op <= OP_PIXEL;
			pixel <= '0;
			frame_start <= 1'b0;
			table_index <= '0;
			table_value <= '0;
		end else begin
			if (pix_valid && !pix_stall) begin
				pack_request(driven_request);
				accepted_total++;
			end
			if (!pix_valid || !pix_stall) begin
				if (pixel_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_request = pixel_requests.pop_front();
					pix_valid <= 1'b1;
					op <= driven_request.op;
					pixel <= driven_request.pixel;
					frame_start <= driven_request.frame_start;
					table_index <= driven_request.table_index;
					table_value <= driven_request.table_value;
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		mono_result_t want;
		if (!arst_n) begin
			byte_stall <= 1'b0;
		end else begin
			byte_stall <= ($urandom_range(99) < stall_pct);
			if (byte_valid && !byte_stall) begin
				if (pending_bytes.size() == 0) begin
					if (error_count < REPORT_LIMIT)
						$display("unexpected byte %h row %0d column %0d last %b",
							mono_byte, out_row, byte_column, last);
					error_count++;
				end else begin
					want = pending_bytes.pop_front();
					if (mono_byte !== want.mono_byte || out_row !== want.out_row
							|| byte_column !== want.byte_column || last !== want.last) begin
						if (error_count < REPORT_LIMIT)
							$display("byte mismatch: expected %h row %0d column %0d last %b, got %h row %0d column %0d last %b",
								want.mono_byte, want.out_row, want.byte_column, want.last,
								mono_byte, out_row, byte_column, last);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && !pix_stall) || (byte_valid && !byte_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic void push_request(input op_t kind, input int level, input bit start,
			input int index, input int value);
		pixel_request_t r;
		r.op = kind;
		r.pixel = 8'(level);
		r.frame_start = start;
		r.table_index = 8'(index);
		r.table_value = 8'(value);
		if (kind == OP_TABLE && !level_mapped[r.table_index]) begin
			level_mapped[r.table_index] = 1'b1;
			mapped_levels.push_back(int'(r.table_index));
		end
		pixel_requests.push_back(r);
		queued_total++;
	endfunction

	task automatic wait_idle();
		while (accepted_total != queued_total || pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int scale, input int width, input int white,
			input int black);
		int values [4];
		int i;
		values = '{scale, width, white, black};
		for (i = 0; i < 4; i++) begin
			cfg_index <= 2'(i);
			cfg_data <= 11'(values[i]);
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			case (cfg_reg_t'(i))
				CFG_SCALE_MODE:  scale_reg = 4'(values[i]);
				CFG_LINE_WIDTH:  width_reg = 11'(values[i]);
				CFG_WHITE_VALUE: white_reg = values[i][0];
				CFG_BLACK_VALUE: black_reg = values[i][0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic void set_idle(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 16 : 0;
		stall_pct = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 16 : 0;
	endfunction

	// Raster frames of random grey levels, with grey map writes and stray frame starts mixed in.
	task automatic run_phase(input int scale, input int width, input int white, input int black,
			input idle_mode_t mode, input int count, input int left_init, input int frame_len,
			input int table_pct, input int break_pct);
		int line_len;
		int left;
		int i;
		bit start;
		wait_idle();
		configure(scale, width, white, black);
		set_idle(mode);
		line_len = (width > MAX_WIDTH) ? MAX_WIDTH : (width == 0) ? 1 : width;
		left = left_init;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(99) < table_pct) begin
				push_request(OP_TABLE, $urandom_range(255), $urandom_range(1),
					$urandom_range(255), $urandom_range(255));
			end else begin
				start = 1'b0;
				if (left == 0) begin
					left = (frame_len > 0) ? frame_len : $urandom_range(1, 6) * line_len;
					start = 1'b1;
				end else if ($urandom_range(99) < break_pct) begin
					start = 1'b1;
				end
				left--;
				push_request(OP_PIXEL,
					mapped_levels[$urandom_range(mapped_levels.size() - 1)], start,
					$urandom_range(255), $urandom_range(255));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(0, 8, 1, 0);
		set_idle(IDLE_NONE);
		push_request(OP_TABLE, 8'h5a, 1'b1, 0, 0);
		push_request(OP_TABLE, 8'ha5, 1'b0, 255, 255);
		push_request(OP_TABLE, 8'h00, 1'b1, 1, 1);
		push_request(OP_TABLE, 8'hff, 1'b0, 128, 128);
		push_request(OP_TABLE, 8'h0f, 1'b1, 127, 127);
		push_request(OP_TABLE, 8'hf0, 1'b0, 85, 170);
		push_request(OP_TABLE, 8'h33, 1'b1, 170, 85);
		push_request(OP_PIXEL, 255, 1'b1, 8'hff, 8'hff);
		push_request(OP_PIXEL, 0, 1'b0, 8'h00, 8'h00);
		push_request(OP_PIXEL, 128, 1'b0, 8'haa, 8'h55);
		push_request(OP_PIXEL, 127, 1'b0, 8'h55, 8'haa);
		push_request(OP_PIXEL, 85, 1'b0, 8'h01, 8'h80);
		push_request(OP_PIXEL, 170, 1'b0, 8'h80, 8'h01);
		push_request(OP_PIXEL, 1, 1'b0, 8'h7f, 8'hfe);
		push_request(OP_PIXEL, 255, 1'b0, 8'hfe, 8'h7f);
		// A grey map write with frame start set must leave the line counters alone.
		push_request(OP_TABLE, 255, 1'b1, 2, 200);
		push_request(OP_PIXEL, 2, 1'b0, 8'h00, 8'hff);
		push_request(OP_PIXEL, 255, 1'b0, 8'hff, 8'h00);
		push_request(OP_PIXEL, 0, 1'b0, 8'h0f, 8'hf0);
		push_request(OP_PIXEL, 128, 1'b0, 8'hf0, 8'h0f);

		run_phase(0, 8, 1, 0, IDLE_SEND, 60, $urandom_range(8), 0, 6, 3);
		run_phase(1, 16, 0, 1, IDLE_RECV, 60, $urandom_range(8), 0, 6, 3);
		run_phase(2, 40, 1, 1, IDLE_BOTH, 60, $urandom_range(8), 0, 6, 3);
		run_phase(3, 24, 0, 0, IDLE_NONE, 50, $urandom_range(8), 0, 6, 3);
		run_phase(8, 64, 1, 0, IDLE_SEND, 70, $urandom_range(8), 0, 4, 2);
		run_phase(15, 64, 1, 0, IDLE_RECV, 70, $urandom_range(8), 0, 4, 2);
		// Zero width ends every line, so 1023 pixels bring the output row to its top value.
		run_phase(0, 0, 1, 0, IDLE_BOTH, 1023, 0, 1040, 0, 0);
		run_phase(0, 8, 1, 0, IDLE_NONE, 40, 16, 0, 6, 3);
		run_phase(0, 2047, 1, 0, IDLE_SEND, 100, 0, 0, 3, 0);
		run_phase(4, 32, 1, 0, IDLE_RECV, 50, $urandom_range(8), 0, 6, 3);
		run_phase(0, 10, 0, 1, IDLE_BOTH, 40, $urandom_range(8), 0, 6, 3);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_bytes.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
